[sv/ppc_pkg.sv]
// shared types, codes and constants for the packet priority classifier
package ppc_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam int ID_W      = 16;
    localparam int TIME_W    = 32;
    localparam int BCNT_W    = 8;
    localparam int PCT_W     = 7;
    localparam int MV_W      = 16;
    localparam int RSSI_W    = 9;
    localparam int SNR_W     = 8;
    localparam int LEVEL_W   = 2;
    localparam int BACKOFF_W = 10;
    localparam int REASON_W  = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [BACKOFF_W-1:0] BACKOFF_STANDARD = 10'd800;
    localparam logic [BACKOFF_W-1:0] BACKOFF_SOS      = 10'd20;
    localparam logic [BACKOFF_W-1:0] BACKOFF_BURST    = 10'd0;
    localparam logic [BACKOFF_W-1:0] BACKOFF_DISTRESS = 10'd30;
    localparam logic [BACKOFF_W-1:0] BACKOFF_ACK      = 10'd150;
    localparam logic [BACKOFF_W-1:0] BACKOFF_DEGRADED = 10'd250;

    localparam logic [PCT_W-1:0] LOSS_DEGRADED = 7'd30;

    localparam logic [TIME_W-1:0]        RST_BURST_WINDOW = 32'd30000;
    localparam logic [PCT_W-1:0]         RST_CRIT_PCT     = 7'd15;
    localparam logic [MV_W-1:0]          RST_CRIT_MV      = 16'd3350;
    localparam logic [PCT_W-1:0]         RST_CRIT_LOSS    = 7'd45;
    localparam logic signed [RSSI_W-1:0] RST_EXT_RSSI     = -9'sd120;
    localparam logic signed [SNR_W-1:0]  RST_EXT_SNR      = -8'sd56;
    localparam logic [PCT_W-1:0]         RST_EXT_LOSS     = 7'd75;
    localparam logic [PCT_W-1:0]         RST_WARN_PCT     = 7'd25;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BURST_WINDOW = 3'd0,
        CFG_CRIT_PCT     = 3'd1,
        CFG_CRIT_MV      = 3'd2,
        CFG_CRIT_LOSS    = 3'd3,
        CFG_EXT_RSSI     = 3'd4,
        CFG_EXT_SNR      = 3'd5,
        CFG_EXT_LOSS     = 3'd6,
        CFG_WARN_PCT     = 3'd7
    } t_cfg_idx;

    typedef enum logic [LEVEL_W-1:0] {
        LVL_NORMAL    = 2'd0,
        LVL_ELEVATED  = 2'd1,
        LVL_EMERGENCY = 2'd2
    } t_level;

    typedef enum logic [REASON_W-1:0] {
        RSN_STANDARD   = 3'd0,
        RSN_SOS_DIRECT = 3'd1,
        RSN_SOS_REPEAT = 3'd2,
        RSN_DISTRESS   = 3'd3,
        RSN_ACK        = 3'd4,
        RSN_DEGRADED   = 3'd5
    } t_reason;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_UPDATE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]   sender;
        logic [TIME_W-1:0] stamp;
        logic [BCNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic             load;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             update;
        logic             finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_sos;
    } t_dp_status;

endpackage

[sv/ppc_in_if.sv]
// input item channel of the packet priority classifier
interface ppc_in_if import ppc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     payload_valid;
    logic                     sos_payload;
    logic                     ack_payload;
    logic [ID_W-1:0]          sender_id;
    logic [TIME_W-1:0]        now_ms;
    logic                     tlm_valid;
    logic                     tlm_emergency;
    logic [PCT_W-1:0]         charge_pct;
    logic [MV_W-1:0]          battery_mv;
    logic [PCT_W-1:0]         loss_pct;
    logic signed [RSSI_W-1:0] rssi_dbm;
    logic signed [SNR_W-1:0]  snr_quarter_db;

    modport source (
        output valid, payload_valid, sos_payload, ack_payload, sender_id, now_ms,
               tlm_valid, tlm_emergency, charge_pct, battery_mv, loss_pct,
               rssi_dbm, snr_quarter_db,
        input  ready
    );

    modport sink (
        input  valid, payload_valid, sos_payload, ack_payload, sender_id, now_ms,
               tlm_valid, tlm_emergency, charge_pct, battery_mv, loss_pct,
               rssi_dbm, snr_quarter_db,
        output ready
    );
endinterface

[sv/ppc_out_if.sv]
// result item channel of the packet priority classifier
interface ppc_out_if import ppc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [LEVEL_W-1:0]   level;
    logic                 preemptive;
    logic [BACKOFF_W-1:0] backoff_ms;
    logic [REASON_W-1:0]  reason;
    logic [BCNT_W-1:0]    sos_count;

    modport source (
        output valid, level, preemptive, backoff_ms, reason, sos_count,
        input  ready
    );

    modport sink (
        input  valid, level, preemptive, backoff_ms, reason, sos_count,
        output ready
    );
endinterface

[sv/ppc_ctrl.sv]
// controller: sequences load, table scan, table update and result hand-off
module ppc_ctrl import ppc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_scan_idx, n_scan_idx;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan_idx  <= n_scan_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_scan_idx  = r_scan_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_scan_idx = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_status.is_sos) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = r_scan_idx;
                    if (r_scan_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_scan_idx = r_scan_idx + 1'b1;
                    end
                end
            end
            S_DRAIN: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

[sv/ppc_dp.sv]
// datapath: config registers, burst table, scan trackers and result logic
module ppc_dp import ppc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ppc_in_if.sink                i_in,
    ppc_out_if.source             o_res,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_status
);

    // configuration
    logic [TIME_W-1:0]        r_burst_window;
    logic [PCT_W-1:0]         r_crit_pct;
    logic [MV_W-1:0]          r_crit_mv;
    logic [PCT_W-1:0]         r_crit_loss;
    logic signed [RSSI_W-1:0] r_ext_rssi;
    logic signed [SNR_W-1:0]  r_ext_snr;
    logic [PCT_W-1:0]         r_ext_loss;
    logic [PCT_W-1:0]         r_warn_pct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_window <= RST_BURST_WINDOW;
            r_crit_pct     <= RST_CRIT_PCT;
            r_crit_mv      <= RST_CRIT_MV;
            r_crit_loss    <= RST_CRIT_LOSS;
            r_ext_rssi     <= RST_EXT_RSSI;
            r_ext_snr      <= RST_EXT_SNR;
            r_ext_loss     <= RST_EXT_LOSS;
            r_warn_pct     <= RST_WARN_PCT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BURST_WINDOW: r_burst_window <= i_cfg_data[TIME_W-1:0];
                CFG_CRIT_PCT:     r_crit_pct     <= i_cfg_data[PCT_W-1:0];
                CFG_CRIT_MV:      r_crit_mv      <= i_cfg_data[MV_W-1:0];
                CFG_CRIT_LOSS:    r_crit_loss    <= i_cfg_data[PCT_W-1:0];
                CFG_EXT_RSSI:     r_ext_rssi     <= i_cfg_data[RSSI_W-1:0];
                CFG_EXT_SNR:      r_ext_snr      <= i_cfg_data[SNR_W-1:0];
                CFG_EXT_LOSS:     r_ext_loss     <= i_cfg_data[PCT_W-1:0];
                CFG_WARN_PCT:     r_warn_pct     <= i_cfg_data[PCT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // captured item
    logic                     r_is_sos;
    logic                     r_payload;
    logic                     r_ack;
    logic [ID_W-1:0]          r_id;
    logic [TIME_W-1:0]        r_now;
    logic                     r_tlm;
    logic                     r_emerg;
    logic [PCT_W-1:0]         r_bpct;
    logic [MV_W-1:0]          r_bmv;
    logic [PCT_W-1:0]         r_loss;
    logic signed [RSSI_W-1:0] r_rssi;
    logic signed [SNR_W-1:0]  r_snr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_sos <= 1'b0;
        end else if (i_cmd.load) begin
            r_is_sos <= i_in.payload_valid && i_in.sos_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_payload <= i_in.payload_valid;
            r_ack     <= i_in.ack_payload;
            r_id      <= i_in.sender_id;
            r_now     <= i_in.now_ms;
            r_tlm     <= i_in.tlm_valid;
            r_emerg   <= i_in.tlm_emergency;
            r_bpct    <= i_in.charge_pct;
            r_bmv     <= i_in.battery_mv;
            r_loss    <= i_in.loss_pct;
            r_rssi    <= i_in.rssi_dbm;
            r_snr     <= i_in.snr_quarter_db;
        end
    end

    assign o_status.is_sos = r_is_sos;

    // burst table
    t_entry                   r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_used;
    t_entry                   r_rd_entry;
    logic                     r_rd_used;
    logic [IDX_W-1:0]         r_rd_idx;
    logic                     r_rd_vld;

    logic [IDX_W-1:0]  w_pick;
    logic [BCNT_W-1:0] w_new_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_entry <= r_mem[i_cmd.rd_addr];
            r_rd_used  <= r_used[i_cmd.rd_addr];
            r_rd_idx   <= i_cmd.rd_addr;
        end
        if (i_cmd.update) begin
            r_mem[w_pick] <= '{sender: r_id, stamp: r_now, count: w_new_count};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.update) begin
                r_used[w_pick] <= 1'b1;
            end
        end
    end

    // entries never written read as empty
    logic [ID_W-1:0]   w_rd_sender;
    logic [TIME_W-1:0] w_rd_stamp;
    logic [BCNT_W-1:0] w_rd_count;

    assign w_rd_sender = r_rd_used ? r_rd_entry.sender : '0;
    assign w_rd_stamp  = r_rd_used ? r_rd_entry.stamp  : '0;
    assign w_rd_count  = r_rd_used ? r_rd_entry.count  : '0;

    // scan trackers
    logic              r_found;
    logic [IDX_W-1:0]  r_match_idx;
    logic [TIME_W-1:0] r_match_stamp;
    logic [BCNT_W-1:0] r_match_count;
    logic              r_has_empty;
    logic [IDX_W-1:0]  r_empty_idx;
    logic [IDX_W-1:0]  r_oldest_idx;
    logic [TIME_W-1:0] r_oldest_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found     <= 1'b0;
            r_has_empty <= 1'b0;
        end else if (i_cmd.load) begin
            r_found     <= 1'b0;
            r_has_empty <= 1'b0;
        end else if (r_rd_vld && !r_found) begin
            if (w_rd_sender == r_id) begin
                r_found <= 1'b1;
            end
            if (w_rd_sender == '0 && !r_has_empty) begin
                r_has_empty <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_oldest_stamp <= '1;
            r_oldest_idx   <= '0;
        end else if (r_rd_vld && !r_found) begin
            if (w_rd_sender == r_id) begin
                r_match_idx   <= r_rd_idx;
                r_match_stamp <= w_rd_stamp;
                r_match_count <= w_rd_count;
            end
            if (w_rd_sender == '0 && !r_has_empty) begin
                r_empty_idx <= r_rd_idx;
            end
            if (w_rd_stamp < r_oldest_stamp) begin
                r_oldest_stamp <= w_rd_stamp;
                r_oldest_idx   <= r_rd_idx;
            end
        end
    end

    // table update
    logic [TIME_W-1:0] w_gap;
    logic              w_repeat;

    assign w_pick   = r_found ? r_match_idx : (r_has_empty ? r_empty_idx : r_oldest_idx);
    assign w_gap    = r_now - r_match_stamp;
    assign w_repeat = (w_gap <= r_burst_window);

    always_comb begin
        if (!r_found || !w_repeat) begin
            w_new_count = BCNT_W'(1);
        end else if (r_match_count == '1) begin
            w_new_count = r_match_count;
        end else begin
            w_new_count = r_match_count + 1'b1;
        end
    end

    logic [BCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_count <= '0;
        end else if (i_cmd.update) begin
            r_count <= w_new_count;
        end
    end

    // classification
    logic w_crit;
    logic w_extreme;
    logic w_distress;
    logic w_degraded;

    assign w_crit     = (r_bpct < r_crit_pct || r_bmv < r_crit_mv) && (r_loss > r_crit_loss);
    assign w_extreme  = (r_rssi < r_ext_rssi) && (r_snr < r_ext_snr) && (r_loss > r_ext_loss);
    assign w_distress = r_tlm && (r_emerg || w_crit || w_extreme);
    assign w_degraded = r_tlm && (r_bpct < r_warn_pct || r_loss > LOSS_DEGRADED);

    logic [LEVEL_W-1:0]   n_level,   r_level;
    logic                 n_pre,     r_pre;
    logic [BACKOFF_W-1:0] n_backoff, r_backoff;
    logic [REASON_W-1:0]  n_reason,  r_reason;
    logic [BCNT_W-1:0]    n_bcount,  r_bcount;

    always_comb begin
        n_level   = LVL_NORMAL;
        n_pre     = 1'b0;
        n_backoff = BACKOFF_STANDARD;
        n_reason  = RSN_STANDARD;
        n_bcount  = '0;
        if (r_payload) begin
            if (r_is_sos) begin
                n_level   = LVL_EMERGENCY;
                n_pre     = 1'b1;
                n_backoff = (r_count > BCNT_W'(2)) ? BACKOFF_BURST : BACKOFF_SOS;
                n_reason  = (r_count > BCNT_W'(1)) ? RSN_SOS_REPEAT : RSN_SOS_DIRECT;
                n_bcount  = r_count;
            end else if (w_distress) begin
                n_level   = LVL_EMERGENCY;
                n_pre     = 1'b1;
                n_backoff = BACKOFF_DISTRESS;
                n_reason  = RSN_DISTRESS;
            end else if (r_ack) begin
                n_level   = LVL_ELEVATED;
                n_backoff = BACKOFF_ACK;
                n_reason  = RSN_ACK;
            end else if (w_degraded) begin
                n_level   = LVL_ELEVATED;
                n_backoff = BACKOFF_DEGRADED;
                n_reason  = RSN_DEGRADED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_level   <= n_level;
            r_pre     <= n_pre;
            r_backoff <= n_backoff;
            r_reason  <= n_reason;
            r_bcount  <= n_bcount;
        end
    end

    assign o_res.level      = r_level;
    assign o_res.preemptive = r_pre;
    assign o_res.backoff_ms = r_backoff;
    assign o_res.reason     = r_reason;
    assign o_res.sos_count  = r_bcount;

endmodule

[sv/packet_priority_classifier_unit.sv]
// top level of the packet priority classifier
//
//  channel   dir  handshake          contents
//  i_in      in   valid / ready      packet flags, sender, time, telemetry
//  o_res     out  valid / ready      level, preemption, backoff, reason, burst count
//  i_cfg_*   in   write enable only  register index and write data
//
// an sos item goes through load, a read of each burst table entry, then read
// drain, table update and result load; other items skip the reads, drain and update
// the burst table read port, one entry a cycle, paces the sos scan
// reset clears the table valid bits and restores register defaults at once
// a new item is taken while an earlier result waits in the output register;
// the result load waits for that register to empty
module packet_priority_classifier_unit import ppc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ppc_in_if.sink                i_in,
    ppc_out_if.source             o_res
);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;
    logic       w_out_valid;

    ppc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (w_out_valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    ppc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_res      (o_res),
        .i_cmd      (w_cmd),
        .o_status   (w_status)
    );

    assign i_in.ready  = w_in_ready;
    assign o_res.valid = w_out_valid;

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("item accepted while another is in work");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> (!o_res.valid || o_res.ready))
        else $error("result load over a waiting result");

    a_update_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.update |-> $past(w_cmd.rd_en, 2))
        else $error("table update without a completed scan");

    a_count_sos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((o_res.sos_count != '0) ==
            (o_res.reason == RSN_SOS_DIRECT || o_res.reason == RSN_SOS_REPEAT)))
        else $error("burst count disagrees with reason");
`endif

endmodule

[sim/ppc_result_checker.sv]
// checker for the packet priority classifier: predicts each result and compares it
module ppc_result_checker import ppc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ppc_in_if                     i_in,
    ppc_out_if                    i_res,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_sos_seen
);

    typedef struct packed {
        logic              payload;
        logic              sos;
        logic              ack;
        logic [ID_W-1:0]   sender;
        logic [TIME_W-1:0] now;
        logic              tlm;
        logic              emerg;
        logic [PCT_W-1:0]  bpct;
        logic [MV_W-1:0]   bmv;
        logic [PCT_W-1:0]  loss;
        logic [RSSI_W-1:0] rssi;
        logic [SNR_W-1:0]  snr;
    } t_pkt;

    typedef struct packed {
        t_level               level;
        logic                 pre;
        logic [BACKOFF_W-1:0] backoff;
        t_reason              reason;
        logic [BCNT_W-1:0]    count;
    } t_prio;

    logic [TIME_W-1:0]        win;
    logic [PCT_W-1:0]         crit_pct;
    logic [MV_W-1:0]          crit_mv;
    logic [PCT_W-1:0]         crit_loss;
    logic signed [RSSI_W-1:0] ext_rssi;
    logic signed [SNR_W-1:0]  ext_snr;
    logic [PCT_W-1:0]         ext_loss;
    logic [PCT_W-1:0]         warn_pct;

    logic [ID_W-1:0]   tab_id   [TABLE_ENTRIES];
    logic [TIME_W-1:0] tab_time [TABLE_ENTRIES];
    logic [BCNT_W-1:0] tab_cnt  [TABLE_ENTRIES];

    t_prio predicted_prio_q [$];
    int    n_fail = 0;
    int    n_checked = 0;
    int    n_sos = 0;

    assign o_fail_count = n_fail;
    assign o_checked    = n_checked;
    assign o_sos_seen   = n_sos;

    function automatic void clear_model();
        win       = RST_BURST_WINDOW;
        crit_pct  = RST_CRIT_PCT;
        crit_mv   = RST_CRIT_MV;
        crit_loss = RST_CRIT_LOSS;
        ext_rssi  = RST_EXT_RSSI;
        ext_snr   = RST_EXT_SNR;
        ext_loss  = RST_EXT_LOSS;
        warn_pct  = RST_WARN_PCT;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tab_id[i]   = '0;
            tab_time[i] = '0;
            tab_cnt[i]  = '0;
        end
    endfunction

    function automatic void write_setting(input t_cfg_idx idx,
                                          input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_BURST_WINDOW: win       = data[TIME_W-1:0];
            CFG_CRIT_PCT:     crit_pct  = data[PCT_W-1:0];
            CFG_CRIT_MV:      crit_mv   = data[MV_W-1:0];
            CFG_CRIT_LOSS:    crit_loss = data[PCT_W-1:0];
            CFG_EXT_RSSI:     ext_rssi  = data[RSSI_W-1:0];
            CFG_EXT_SNR:      ext_snr   = data[SNR_W-1:0];
            CFG_EXT_LOSS:     ext_loss  = data[PCT_W-1:0];
            CFG_WARN_PCT:     warn_pct  = data[PCT_W-1:0];
            default: ;
        endcase
    endfunction

    // own entry, else first empty slot, else entry with the oldest time
    function automatic logic [BCNT_W-1:0] bump_burst(input logic [ID_W-1:0] id,
                                                     input logic [TIME_W-1:0] now);
        int                slot;
        int                oldest;
        logic [TIME_W-1:0] oldest_t;
        logic [TIME_W-1:0] gap;
        logic              found;
        slot     = -1;
        oldest   = 0;
        oldest_t = '1;
        found    = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!found) begin
                if (tab_id[i] == id) begin
                    slot  = i;
                    found = 1'b1;
                end else begin
                    if (tab_id[i] == '0 && slot < 0) slot = i;
                    if (tab_time[i] < oldest_t) begin
                        oldest_t = tab_time[i];
                        oldest   = i;
                    end
                end
            end
        end
        if (slot < 0) slot = oldest;
        if (tab_id[slot] == id) begin
            gap = now - tab_time[slot];
            if (gap <= win) begin
                if (tab_cnt[slot] != '1) tab_cnt[slot] = tab_cnt[slot] + 1'b1;
            end else begin
                tab_cnt[slot] = BCNT_W'(1);
            end
        end else begin
            tab_id[slot]  = id;
            tab_cnt[slot] = BCNT_W'(1);
        end
        tab_time[slot] = now;
        return tab_cnt[slot];
    endfunction

    function automatic t_prio classify_packet(input t_pkt p);
        t_prio r;
        logic  distress;
        r.level   = LVL_NORMAL;
        r.pre     = 1'b0;
        r.backoff = BACKOFF_STANDARD;
        r.reason  = RSN_STANDARD;
        r.count   = '0;
        distress  = p.tlm && (p.emerg
                    || ((p.bpct < crit_pct || p.bmv < crit_mv) && p.loss > crit_loss)
                    || ($signed(p.rssi) < ext_rssi && $signed(p.snr) < ext_snr
                        && p.loss > ext_loss));
        if (p.payload) begin
            if (p.sos) begin
                r.count   = bump_burst(p.sender, p.now);
                r.level   = LVL_EMERGENCY;
                r.pre     = 1'b1;
                r.backoff = (r.count > 2) ? BACKOFF_BURST : BACKOFF_SOS;
                if (r.count > 1) r.reason = RSN_SOS_REPEAT;
                else r.reason = RSN_SOS_DIRECT;
            end else if (distress) begin
                r.level   = LVL_EMERGENCY;
                r.pre     = 1'b1;
                r.backoff = BACKOFF_DISTRESS;
                r.reason  = RSN_DISTRESS;
            end else if (p.ack) begin
                r.level   = LVL_ELEVATED;
                r.backoff = BACKOFF_ACK;
                r.reason  = RSN_ACK;
            end else if (p.tlm && (p.bpct < warn_pct || p.loss > LOSS_DEGRADED)) begin
                r.level   = LVL_ELEVATED;
                r.backoff = BACKOFF_DEGRADED;
                r.reason  = RSN_DEGRADED;
            end
        end
        return r;
    endfunction

    // report fields: level/preemptive/backoff/reason/burst count
    always @(posedge i_clk) begin
        t_pkt  seen;
        t_prio want;
        if (!i_rst_n) begin
            clear_model();
            predicted_prio_q.delete();
        end else begin
            if (i_cfg_we) write_setting(i_cfg_idx, i_cfg_data);
            if (i_res.valid && i_res.ready) begin
                n_checked++;
                if (predicted_prio_q.size() == 0) begin
                    if (n_fail < 10)
                        $display("unexpected result: %0d/%0d/%0d/%0d/%0d",
                                 i_res.level, i_res.preemptive, i_res.backoff_ms,
                                 i_res.reason, i_res.sos_count);
                    n_fail++;
                end else begin
                    want = predicted_prio_q.pop_front();
                    if (i_res.level !== want.level || i_res.preemptive !== want.pre
                        || i_res.backoff_ms !== want.backoff || i_res.reason !== want.reason
                        || i_res.sos_count !== want.count) begin
                        if (n_fail < 10)
                            $display("result %0d: expected %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
                                     n_checked, want.level, want.pre, want.backoff, want.reason,
                                     want.count, i_res.level, i_res.preemptive, i_res.backoff_ms,
                                     i_res.reason, i_res.sos_count);
                        n_fail++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                seen.payload = i_in.payload_valid;
                seen.sos     = i_in.sos_payload;
                seen.ack     = i_in.ack_payload;
                seen.sender  = i_in.sender_id;
                seen.now     = i_in.now_ms;
                seen.tlm     = i_in.tlm_valid;
                seen.emerg   = i_in.tlm_emergency;
                seen.bpct    = i_in.charge_pct;
                seen.bmv     = i_in.battery_mv;
                seen.loss    = i_in.loss_pct;
                seen.rssi    = i_in.rssi_dbm;
                seen.snr     = i_in.snr_quarter_db;
                if (seen.payload && seen.sos) n_sos++;
                predicted_prio_q.push_back(classify_packet(seen));
            end
        end
        o_pending <= predicted_prio_q.size();
    end

endmodule

[sim/tb_packet_priority_classifier_unit.sv]
// testbench top for the packet priority classifier: stimulus, flow control and verdict
module tb_packet_priority_classifier_unit;
    import ppc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_SIZE   = 12;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic              payload;
        logic              sos;
        logic              ack;
        logic [ID_W-1:0]   sender;
        logic [TIME_W-1:0] now;
        logic              tlm;
        logic              emerg;
        logic [PCT_W-1:0]  bpct;
        logic [MV_W-1:0]   bmv;
        logic [PCT_W-1:0]  loss;
        logic [RSSI_W-1:0] rssi;
        logic [SNR_W-1:0]  snr;
    } t_pkt;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  steady;
    logic                  hold_armed;

    int fail_count;
    int pending;
    int checked;
    int sos_seen;
    int sent = 0;
    int cycle_cnt = 0;

    logic [TIME_W-1:0] clock_ms;
    logic [TIME_W-1:0] burst_win;
    logic [ID_W-1:0]   id_pool [POOL_SIZE];

    ppc_in_if  in_ch ();
    ppc_out_if res_ch ();

    packet_priority_classifier_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_res      (res_ch)
    );

    ppc_result_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in         (in_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_sos_seen   (sos_seen)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off once armed
    initial begin : result_sink
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= steady || ($urandom_range(0, 99) >= 22);
            end
        end
    end

    task automatic put_packet(input t_pkt p);
        in_ch.payload_valid  <= p.payload;
        in_ch.sos_payload    <= p.sos;
        in_ch.ack_payload    <= p.ack;
        in_ch.sender_id      <= p.sender;
        in_ch.now_ms         <= p.now;
        in_ch.tlm_valid      <= p.tlm;
        in_ch.tlm_emergency  <= p.emerg;
        in_ch.charge_pct     <= p.bpct;
        in_ch.battery_mv     <= p.bmv;
        in_ch.loss_pct       <= p.loss;
        in_ch.rssi_dbm       <= p.rssi;
        in_ch.snr_quarter_db <= p.snr;
    endtask

    task automatic send_item(input t_pkt p);
        while (!steady && $urandom_range(0, 99) < 22) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        put_packet(p);
        in_ch.valid <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [TIME_W-1:0] window,
                                 input logic [PCT_W-1:0] c_pct,
                                 input logic [MV_W-1:0] c_mv,
                                 input logic [PCT_W-1:0] c_loss,
                                 input logic signed [RSSI_W-1:0] e_rssi,
                                 input logic signed [SNR_W-1:0] e_snr,
                                 input logic [PCT_W-1:0] e_loss,
                                 input logic [PCT_W-1:0] w_pct);
        drain();
        repeat (3) @(posedge clk);
        write_reg(CFG_BURST_WINDOW, window);
        write_reg(CFG_CRIT_PCT, CFG_DATA_W'(c_pct));
        write_reg(CFG_CRIT_MV, CFG_DATA_W'(c_mv));
        write_reg(CFG_CRIT_LOSS, CFG_DATA_W'(c_loss));
        write_reg(CFG_EXT_RSSI, CFG_DATA_W'(e_rssi));
        write_reg(CFG_EXT_SNR, CFG_DATA_W'(e_snr));
        write_reg(CFG_EXT_LOSS, CFG_DATA_W'(e_loss));
        write_reg(CFG_WARN_PCT, CFG_DATA_W'(w_pct));
        cfg_we    <= 1'b0;
        burst_win = window;
    endtask

    function automatic t_pkt quiet_pkt();
        t_pkt p;
        p         = '0;
        p.payload = 1'b1;
        p.bpct    = 7'd100;
        p.bmv     = 16'd4000;
        return p;
    endfunction

    function automatic t_pkt sos_pkt(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] now);
        t_pkt p;
        p        = quiet_pkt();
        p.sos    = 1'b1;
        p.sender = id;
        p.now    = now;
        return p;
    endfunction

    function automatic t_pkt tlm_pkt(input logic emerg, input logic [PCT_W-1:0] bpct,
                                     input logic [MV_W-1:0] bmv, input logic [PCT_W-1:0] loss,
                                     input logic [RSSI_W-1:0] rssi,
                                     input logic [SNR_W-1:0] snr);
        t_pkt p;
        p       = quiet_pkt();
        p.tlm   = 1'b1;
        p.emerg = emerg;
        p.bpct  = bpct;
        p.bmv   = bmv;
        p.loss  = loss;
        p.rssi  = rssi;
        p.snr   = snr;
        return p;
    endfunction

    // mostly senders from a small pool so bursts, repeats and evictions happen
    function automatic t_pkt random_packet();
        t_pkt p;
        p.payload = ($urandom_range(0, 19) != 0);
        p.sos     = ($urandom_range(0, 99) < 45);
        p.ack     = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) p.sender = ID_W'($urandom);
        else p.sender = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        case ($urandom_range(0, 9))
            0, 1, 2, 3: clock_ms = clock_ms + $urandom_range(0, 200);
            4, 5, 6:    clock_ms = clock_ms + burst_win + TIME_W'($urandom_range(0, 4)) - 32'd2;
            7, 8:       clock_ms = clock_ms + $urandom_range(0, 100000);
            default:    clock_ms = $urandom;
        endcase
        p.now   = clock_ms;
        p.tlm   = ($urandom_range(0, 3) != 0);
        p.emerg = ($urandom_range(0, 9) == 0);
        p.bpct  = PCT_W'($urandom_range(0, 100));
        if ($urandom_range(0, 1) != 0) p.bmv = MV_W'($urandom_range(3200, 3500));
        else p.bmv = MV_W'($urandom);
        p.loss  = PCT_W'($urandom_range(0, 100));
        if ($urandom_range(0, 1) != 0) p.rssi = RSSI_W'($urandom_range(0, 20)) - 9'd130;
        else p.rssi = RSSI_W'($urandom);
        if ($urandom_range(0, 1) != 0) p.snr = SNR_W'($urandom_range(0, 20)) - 8'd66;
        else p.snr = SNR_W'($urandom);
        return p;
    endfunction

    task automatic random_phase(input int n, input logic zero_in_pool);
        for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = ID_W'($urandom_range(1, 65535));
        if (zero_in_pool) id_pool[POOL_SIZE - 1] = '0;
        for (int k = 0; k < n; k++) send_item(random_packet());
    endtask

    task automatic run_directed();
        t_pkt p;
        // no payload gives the default and leaves the table alone
        p         = tlm_pkt(1'b1, 7'd0, 16'd0, 7'd100, 9'h100, 8'h80);
        p.payload = 1'b0;
        p.sos     = 1'b1;
        p.ack     = 1'b1;
        p.sender  = 16'hFFFF;
        p.now     = '1;
        send_item(p);
        send_item(quiet_pkt());
        // burst growth, gap exactly at the window, then just past it
        send_item(sos_pkt(16'h1234, 32'd1000));
        send_item(sos_pkt(16'h1234, 32'd31000));
        send_item(sos_pkt(16'h1234, 32'd61000));
        send_item(sos_pkt(16'h1234, 32'd91001));
        // sender zero lands on the first empty slot as a repeat
        send_item(sos_pkt(16'h0000, 32'd5));
        send_item(sos_pkt(16'h0000, 32'd10));
        // time wraps between two packets of a burst
        send_item(sos_pkt(16'hFFFF, 32'hFFFF_FFF0));
        send_item(sos_pkt(16'hFFFF, 32'h0000_0010));
        p     = tlm_pkt(1'b1, 7'd100, 16'd4000, 7'd0, 9'd0, 8'd0);
        p.ack = 1'b1;
        send_item(p);
        send_item(tlm_pkt(1'b0, 7'd14, 16'd4000, 7'd46, 9'd0, 8'd0));
        send_item(tlm_pkt(1'b0, 7'd15, 16'd3349, 7'd46, 9'd0, 8'd0));
        send_item(tlm_pkt(1'b0, 7'd15, 16'd3350, 7'd46, 9'd0, 8'd0));
        send_item(tlm_pkt(1'b0, 7'd14, 16'd4000, 7'd45, 9'd0, 8'd0));
        send_item(tlm_pkt(1'b0, 7'd100, 16'hFFFF, 7'd76, -9'sd121, -8'sd57));
        send_item(tlm_pkt(1'b0, 7'd100, 16'hFFFF, 7'd76, -9'sd120, -8'sd57));
        p     = quiet_pkt();
        p.ack = 1'b1;
        send_item(p);
        p     = tlm_pkt(1'b0, 7'd24, 16'd4000, 7'd0, 9'd0, 8'd0);
        p.ack = 1'b1;
        send_item(p);
        send_item(tlm_pkt(1'b0, 7'd24, 16'd4000, 7'd0, 9'd0, 8'd0));
        send_item(tlm_pkt(1'b0, 7'd25, 16'd4000, 7'd30, 9'd0, 8'd0));
        // sos wins over telemetry distress
        p       = sos_pkt(16'h00A5, 32'h8000_0000);
        p.tlm   = 1'b1;
        p.emerg = 1'b1;
        send_item(p);
        send_item(tlm_pkt(1'b0, 7'd100, 16'hFFFF, 7'd100, 9'h0FF, 8'h7F));
        send_item(tlm_pkt(1'b0, 7'd0, 16'd0, 7'd0, 9'h100, 8'h80));
    endtask

    initial begin : stimulus
        logic [ID_W-1:0] sat_id;
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_idx    <= CFG_BURST_WINDOW;
        cfg_data   <= '0;
        steady     <= 1'b0;
        hold_armed <= 1'b0;
        in_ch.valid <= 1'b0;
        put_packet('0);
        clock_ms  = '0;
        burst_win = RST_BURST_WINDOW;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        load_settings(RST_BURST_WINDOW, RST_CRIT_PCT, RST_CRIT_MV, RST_CRIT_LOSS,
                      RST_EXT_RSSI, RST_EXT_SNR, RST_EXT_LOSS, RST_WARN_PCT);
        hold_armed <= 1'b1;
        random_phase(30, 1'b0);

        load_settings('0, 7'd0, 16'd0, 7'd0, 9'h100, 8'h80, 7'd0, 7'd0);
        random_phase(30, 1'b1);

        // widest window: one sender runs its count into saturation
        load_settings('1, 7'd100, 16'hFFFF, 7'd100, 9'h0FF, 8'h7F, 7'd100, 7'd100);
        steady <= 1'b1;
        sat_id = ID_W'($urandom_range(1, 65535));
        for (int k = 0; k < 260; k++) begin
            clock_ms = clock_ms + $urandom_range(0, 5000);
            send_item(sos_pkt(sat_id, clock_ms));
        end
        random_phase(30, 1'b0);
        steady <= 1'b0;

        load_settings(TIME_W'($urandom_range(0, 60000)), PCT_W'($urandom_range(0, 100)),
                      MV_W'($urandom), PCT_W'($urandom_range(0, 100)), RSSI_W'($urandom),
                      SNR_W'($urandom), PCT_W'($urandom_range(0, 100)),
                      PCT_W'($urandom_range(0, 100)));
        random_phase(30, 1'b1);

        drain();
        repeat (20) @(posedge clk);
        $display("sent %0d packets (%0d carrying sos) across five register settings", sent,
                 sos_seen);
        $display("compared %0d results, %0d mismatched", checked, fail_count);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[packet_priority_classifier_unit.f]
sv/ppc_pkg.sv
sv/ppc_in_if.sv
sv/ppc_out_if.sv
sv/ppc_ctrl.sv
sv/ppc_dp.sv
sv/packet_priority_classifier_unit.sv
sim/ppc_result_checker.sv
sim/tb_packet_priority_classifier_unit.sv
